[rtl/lkv_pkg.sv]
// Package with shared types and constants of the key-value cache.
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/lkv_req_if.sv]
// Request channel interface of the key-value cache.
`default_nettype none

interface lkv_req_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, req_type, key, write_value, input ready);
    modport sink (input valid, req_type, key, write_value, output ready);
endinterface

`default_nettype wire

[rtl/lkv_rsp_if.sv]
// Result channel interface of the key-value cache.
`default_nettype none

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

[rtl/lkv_cfg_if.sv]
// Configuration write channel interface of the key-value cache.
`default_nettype none

interface lkv_cfg_if;
    import lkv_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink (input valid, capacity, output ready);
endinterface

`default_nettype wire

[rtl/lkv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/lkv_ctrl.sv]
// Controller state machine sequencing lookup and commit of each request.
`default_nettype none

module lkv_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire lkv_pkg::t_dp_sts i_sts,
    output lkv_pkg::t_dp_cmd      o_cmd
);
    import lkv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = i_req_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            ST_COMMIT: begin
                o_req_ready  = !i_sts.out_busy;
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
        o_cmd.accept = i_req_valid && o_req_ready;
    end

endmodule

`default_nettype wire

[rtl/lkv_dp.sv]
// Datapath with key store, recency ranks, value RAM and result register.
`default_nettype none

module lkv_dp #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lkv_pkg::t_dp_cmd                 i_cmd,
    output lkv_pkg::t_dp_sts                      o_sts,
    input  wire logic                             i_req_type,
    input  wire logic signed [lkv_pkg::KEY_W-1:0] i_key,
    input  wire logic signed [lkv_pkg::VAL_W-1:0] i_write_value,
    input  wire logic                             i_cfg_valid,
    input  wire logic [lkv_pkg::CAP_W-1:0]        i_cfg_capacity,
    output logic                                  o_rsp_valid,
    input  wire logic                             i_rsp_ready,
    output logic                                  o_hit,
    output logic signed [lkv_pkg::VAL_W-1:0]      o_read_value
);
    import lkv_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int FCW = $clog2(ENTRIES + 1);
    localparam int CW  = (FCW > CAP_W) ? FCW : CAP_W;

    logic [CAP_W-1:0] r_capacity;

    logic             r_is_write;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_wval;

    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   r_key_arr [ENTRIES];
    logic [IW-1:0]      r_rank    [ENTRIES];
    logic [FCW-1:0]     r_fill;

    logic          r_hit;
    logic          r_new;
    logic          r_fill_op;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_old_rank;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      victim_idx;
    logic [IW-1:0]      last_rank;
    logic [FCW-1:0]     fill_m1;
    logic [CW-1:0]      cap_eff;
    logic               any_hit;
    logic               fill_ok;
    logic [VAL_W-1:0]   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_write <= (i_req_type == REQ_WRITE);
            r_key      <= i_key;
            r_wval     <= i_write_value;
        end
    end

    assign fill_m1   = r_fill - FCW'(1);
    assign last_rank = fill_m1[IW-1:0];

    always_comb begin
        cap_eff = CW'(r_capacity);
        if (cap_eff == '0) begin
            cap_eff = CW'(1);
        end else if (cap_eff > CW'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end
    end

    assign fill_ok = CW'(r_fill) < cap_eff;

    always_comb begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key_arr[i] == r_key);
            victim[i] = r_valid[i] && (r_rank[i] == last_rank);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
            if (victim[i]) begin
                victim_idx = IW'(i);
            end
        end
    end

    assign any_hit = |match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= any_hit;
            r_old_rank <= r_rank[hit_idx];
            r_new      <= !any_hit;
            r_fill_op  <= !any_hit && fill_ok;
            if (any_hit) begin
                r_slot <= hit_idx;
            end else if (fill_ok) begin
                r_slot <= free_idx;
            end else begin
                r_slot <= victim_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_cmd.commit && r_is_write && !r_hit) begin
            r_valid[r_slot] <= 1'b1;
            if (r_fill_op) begin
                r_fill <= r_fill + FCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_hit || r_is_write)) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == r_slot) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (r_new || (r_rank[i] < r_old_rank))) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
            if (!r_hit) begin
                r_key_arr[r_slot] <= r_key;
            end
        end
    end

    lkv_ram #(
        .WIDTH(VAL_W),
        .DEPTH(ENTRIES)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit && r_is_write),
        .i_waddr(r_slot),
        .i_wdata(r_wval),
        .i_re   (i_cmd.lookup),
        .i_raddr(hit_idx),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            o_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit        <= r_hit;
            o_read_value <= (r_hit && !r_is_write) ? ram_rdata : '0;
        end
    end

    assign o_sts.out_busy = o_rsp_valid && !i_rsp_ready;

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FCW'($countones(r_valid)) == r_fill)
        else $error("fill count differs from number of valid entries");

    a_keys_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> $onehot0(match))
        else $error("key present in more than one entry");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lookup && r_is_write && !any_hit && !fill_ok) |-> (|victim))
        else $error("no least recently used entry found for eviction");

    a_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_is_write) |=> r_valid[$past(r_slot)])
        else $error("written entry not valid after commit");

endmodule

`default_nettype wire

[rtl/lru_key_value_cache_top.sv]
// Top level of the fully associative key-value cache with LRU replacement.
//
// Each request has a lookup step and then a commit step. The lookup compares
// the key against every stored key in parallel and reads the value RAM; the
// commit updates the recency ranks, the key store and the value RAM and loads
// the result register. A new request is taken when idle or during a commit,
// which waits while the result register still holds an untaken result.
// ENTRIES sets the number of slots; the capacity register limits how many are
// filled before eviction of the least recently used entry begins.
`default_nettype none

module lru_key_value_cache_top #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lkv_req_if.sink    i_req,
    lkv_rsp_if.source  o_rsp,
    lkv_cfg_if.sink    i_cfg
);
    import lkv_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lkv_dp #(
        .ENTRIES(ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req.req_type),
        .i_key         (i_req.key),
        .i_write_value (i_req.write_value),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_capacity(i_cfg.capacity),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_hit         (o_rsp.hit),
        .o_read_value  (o_rsp.read_value)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the LRU key-value cache: random requests with random stalls.
`timescale 1ns / 1ps

module testbench;
    import lkv_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 34;
    localparam int SETTLE      = 6;

    typedef struct {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] write_value;
    } t_cache_req;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_lookup_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady_traffic;
    logic req_taken = 1'b0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    t_cache_req     pending_reqs[$];
    t_lookup_result expected_results[$];

    logic             cache_valid[ENTRIES];
    logic [KEY_W-1:0] cache_key[ENTRIES];
    logic [VAL_W-1:0] cache_val[ENTRIES];
    int unsigned      cache_rank[ENTRIES];
    int unsigned      cache_fill;
    logic [CAP_W-1:0] cache_capacity;

    lkv_req_if req_if();
    lkv_rsp_if rsp_if();
    lkv_cfg_if cfg_if();

    lru_key_value_cache_top #(.ENTRIES(ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic promote_entry(input int idx, input int unsigned old_rank);
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (i != idx && cache_valid[i] && cache_rank[i] < old_rank)
                cache_rank[i]++;
        end
        cache_rank[idx] = 0;
    endtask

    task automatic predict_lookup(input t_cache_req rq, output t_lookup_result res);
        int unsigned eff_cap;
        int unsigned worst;
        int          slot;
        int          i;
        bit          found;
        bit          have_free;
        bit          any;
        eff_cap   = (cache_capacity == 0) ? 1 :
                    (cache_capacity > ENTRIES) ? ENTRIES : cache_capacity;
        slot      = 0;
        found     = 1'b0;
        have_free = 1'b0;
        for (i = 0; i < ENTRIES; i++) begin
            if (!found && cache_valid[i] && cache_key[i] == rq.key) begin
                found = 1'b1;
                slot  = i;
            end
        end
        res.hit        = found;
        res.read_value = '0;
        if (found) begin
            if (rq.req_type == REQ_WRITE)
                cache_val[slot] = rq.write_value;
            else
                res.read_value = cache_val[slot];
            promote_entry(slot, cache_rank[slot]);
        end else if (rq.req_type == REQ_WRITE) begin
            if (cache_fill < eff_cap) begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (!have_free && !cache_valid[i]) begin
                        have_free = 1'b1;
                        slot      = i;
                    end
                end
            end
            if (have_free) begin
                cache_fill++;
                promote_entry(slot, ENTRIES);
            end else begin
                any   = 1'b0;
                worst = 0;
                for (i = 0; i < ENTRIES; i++) begin
                    if (cache_valid[i] && (!any || cache_rank[i] > worst)) begin
                        any   = 1'b1;
                        worst = cache_rank[i];
                        slot  = i;
                    end
                end
                if (!any)
                    slot = 0;
                cache_valid[slot] = 1'b0;
                promote_entry(slot, ENTRIES);
            end
            cache_valid[slot] = 1'b1;
            cache_key[slot]   = rq.key;
            cache_val[slot]   = rq.write_value;
        end
    endtask

    always @(posedge i_clk) begin : req_monitor
        t_cache_req     rq;
        t_lookup_result res;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            rq.req_type    = req_if.req_type;
            rq.key         = req_if.key;
            rq.write_value = req_if.write_value;
            predict_lookup(rq, res);
            expected_results.push_back(res);
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_lookup_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result hit=%0b read_value=%h",
                             rsp_if.hit, rsp_if.read_value);
            end else begin
                want = expected_results.pop_front();
                if (rsp_if.hit !== want.hit || rsp_if.read_value !== want.read_value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: expected hit=%0b read_value=%h, ",
                                  "got hit=%0b read_value=%h"},
                                 want.hit, want.read_value,
                                 rsp_if.hit, rsp_if.read_value);
                end
            end
        end
    end

    always @(negedge i_clk) begin : req_driver
        t_cache_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!(req_if.valid && !req_taken)) begin
            if (pending_reqs.size() != 0 &&
                (steady_traffic || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_reqs.pop_front();
                req_if.valid       <= 1'b1;
                req_if.req_type    <= nxt.req_type;
                req_if.key         <= nxt.key;
                req_if.write_value <= nxt.write_value;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= i_rst_n && (steady_traffic || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic add_request(input logic wr, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
        t_cache_req rq;
        rq.req_type    = wr;
        rq.key         = k;
        rq.write_value = v;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.capacity <= cap;
        do
            @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cache_capacity = cap;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] k;
        logic [CAP_W-1:0] cap;
        int unsigned      eff_cap;
        int               phase;
        int               n;
        int               pool_size;

        i_rst_n            = 1'b0;
        steady_traffic     = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_READ;
        req_if.key         = '0;
        req_if.write_value = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.capacity    = CAP_RESET;
        for (n = 0; n < ENTRIES; n++) begin
            cache_valid[n] = 1'b0;
            cache_key[n]   = '0;
            cache_val[n]   = '0;
            cache_rank[n]  = 0;
        end
        cache_fill     = 0;
        cache_capacity = CAP_RESET;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_request(REQ_READ, 32'h0000_0000, 32'h1111_1111);
        add_request(REQ_WRITE, 32'h8000_0000, 32'h7FFF_FFFF);
        add_request(REQ_WRITE, 32'h7FFF_FFFF, 32'h8000_0000);
        add_request(REQ_READ, 32'h8000_0000, 32'h0);
        add_request(REQ_READ, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_request(REQ_WRITE, 32'h8000_0000, 32'h0000_0000);
        add_request(REQ_READ, 32'h8000_0000, 32'h0);
        add_request(REQ_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(REQ_WRITE, 32'hFFFF_FFFF, 32'h0000_0001);
        add_request(REQ_READ, 32'hFFFF_FFFF, 32'h0);
        add_request(REQ_READ, 32'h1234_5678, 32'h0);
        wait_drained();

        // A zero capacity acts as one, and here it also drops below the fill count.
        write_capacity(5'd0);
        add_request(REQ_WRITE, 32'h0000_0055, 32'hA5A5_A5A5);
        add_request(REQ_READ, 32'h0000_0055, 32'h0);
        add_request(REQ_WRITE, 32'h0000_0066, 32'h5A5A_5A5A);
        add_request(REQ_READ, 32'h0000_0055, 32'h0);
        add_request(REQ_READ, 32'h0000_0066, 32'h0);
        add_request(REQ_READ, 32'hFFFF_FFFF, 32'h0);
        wait_drained();

        write_capacity(5'd31);
        add_request(REQ_WRITE, 32'h0000_0077, 32'h0000_0077);
        add_request(REQ_WRITE, 32'h0000_0088, 32'h0000_0088);
        add_request(REQ_READ, 32'h0000_0077, 32'h0);
        add_request(REQ_READ, 32'h8000_0000, 32'h0);
        add_request(REQ_READ, 32'h0000_0066, 32'h0);
        wait_drained();

        for (phase = 0; phase < 9; phase++) begin
            unique case (phase)
                0: cap = 5'd16;
                1: cap = 5'd31;
                2: cap = 5'd1;
                3: cap = 5'd3;
                4: cap = 5'($urandom_range(15, 2));
                5: cap = 5'd0;
                6: cap = 5'($urandom_range(30, 17));
                7: cap = 5'($urandom_range(16, 1));
                default: cap = 5'd16;
            endcase
            write_capacity(cap);
            steady_traffic = (phase == 4);
            eff_cap = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
            pool_size = eff_cap + $urandom_range(6, 1);
            key_pool.delete();
            key_pool.push_back(32'h8000_0000);
            key_pool.push_back(32'h7FFF_FFFF);
            while (key_pool.size() < pool_size)
                key_pool.push_back($urandom);
            for (n = 0; n < 137; n++) begin
                if ($urandom_range(9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                add_request($urandom_range(1) ? REQ_WRITE : REQ_READ, k, $urandom);
            end
            wait_drained();
            steady_traffic = 1'b0;
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
